[rtl/mafhd_pkg.sv]
// ----------------------------------------------------------------------------
// mafhd_pkg
// types, field codes and rate tables for the mpeg audio frame header decoder
// ----------------------------------------------------------------------------
package mafhd_pkg;

    localparam int HDR_W     = 32;
    localparam int KBPS_W    = 9;
    localparam int HZ_W      = 16;
    localparam int LEN_W     = 12;
    localparam int COEF_W    = 18;
    localparam int NUM_W     = 26;
    localparam int RCP_W     = 20;
    localparam int RCP_SHIFT = 32;
    localparam int QUO_W     = NUM_W + RCP_W - RCP_SHIFT;

    localparam logic [7:0] SYNC_BYTE0 = 8'hFF;
    localparam logic [7:0] SYNC_MASK1 = 8'hE0;

    localparam logic [1:0] VER_MPEG25 = 2'd0;
    localparam logic [1:0] VER_RSVD   = 2'd1;
    localparam logic [1:0] VER_MPEG2  = 2'd2;
    localparam logic [1:0] VER_MPEG1  = 2'd3;

    localparam logic [1:0] LAY_RSVD = 2'd0;
    localparam logic [1:0] LAY_III  = 2'd1;
    localparam logic [1:0] LAY_II   = 2'd2;
    localparam logic [1:0] LAY_I    = 2'd3;

    localparam logic [1:0] SRI_44K = 2'd0;
    localparam logic [1:0] SRI_48K = 2'd1;
    localparam logic [1:0] SRI_32K = 2'd2;
    localparam logic [1:0] SRI_RSVD = 2'd3;

    localparam logic [COEF_W-1:0] COEF_L1   = 18'd12000;
    localparam logic [COEF_W-1:0] COEF_HALF = 18'd72000;
    localparam logic [COEF_W-1:0] COEF_FULL = 18'd144000;

    typedef enum logic [1:0] {
        LEN_L1   = 2'b00,
        LEN_FULL = 2'b01,
        LEN_HALF = 2'b10
    } t_len_mode;

    typedef struct packed {
        logic              sync_ok;
        logic [1:0]        version_code;
        logic [1:0]        layer_code;
        logic              crc_present;
        logic              padded;
        logic [KBPS_W-1:0] bitrate_kbps;
        logic [HZ_W-1:0]   sample_rate_hz;
        logic              calc_ok;
        t_len_mode         len_mode;
        logic [RCP_W-1:0]  recip;
    } t_item;

    localparam logic [KBPS_W-1:0] KBPS_V1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V2_L1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V2_L23 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    function automatic logic [KBPS_W-1:0] kbps_lookup(
        input logic [1:0] ver,
        input logic [1:0] lay,
        input logic [3:0] idx
    );
        logic [KBPS_W-1:0] kbps;
        kbps = '0;
        if (ver == VER_RSVD || lay == LAY_RSVD) begin
            kbps = '0;
        end else if (ver == VER_MPEG1) begin
            unique case (lay)
                LAY_I:   kbps = KBPS_V1_L1[idx];
                LAY_II:  kbps = KBPS_V1_L2[idx];
                default: kbps = KBPS_V1_L3[idx];
            endcase
        end else if (lay == LAY_I) begin
            kbps = KBPS_V2_L1[idx];
        end else begin
            kbps = KBPS_V2_L23[idx];
        end
        return kbps;
    endfunction

    function automatic logic [HZ_W-1:0] hz_lookup(
        input logic [1:0] ver,
        input logic [1:0] sri
    );
        logic [HZ_W-1:0] hz;
        hz = '0;
        unique case (ver)
            VER_MPEG1: begin
                unique case (sri)
                    SRI_44K: hz = 16'd44100;
                    SRI_48K: hz = 16'd48000;
                    SRI_32K: hz = 16'd32000;
                    default: hz = '0;
                endcase
            end
            VER_MPEG2: begin
                unique case (sri)
                    SRI_44K: hz = 16'd22050;
                    SRI_48K: hz = 16'd24000;
                    SRI_32K: hz = 16'd16000;
                    default: hz = '0;
                endcase
            end
            VER_MPEG25: begin
                unique case (sri)
                    SRI_44K: hz = 16'd11025;
                    SRI_48K: hz = 16'd12000;
                    SRI_32K: hz = 16'd8000;
                    default: hz = '0;
                endcase
            end
            default: hz = '0;
        endcase
        return hz;
    endfunction

    // floor(2^32 / rate)
    function automatic logic [RCP_W-1:0] recip_lookup(
        input logic [1:0] ver,
        input logic [1:0] sri
    );
        logic [RCP_W-1:0] rcp;
        rcp = '0;
        unique case (ver)
            VER_MPEG1: begin
                unique case (sri)
                    SRI_44K: rcp = 20'd97391;
                    SRI_48K: rcp = 20'd89478;
                    SRI_32K: rcp = 20'd134217;
                    default: rcp = '0;
                endcase
            end
            VER_MPEG2: begin
                unique case (sri)
                    SRI_44K: rcp = 20'd194783;
                    SRI_48K: rcp = 20'd178956;
                    SRI_32K: rcp = 20'd268435;
                    default: rcp = '0;
                endcase
            end
            VER_MPEG25: begin
                unique case (sri)
                    SRI_44K: rcp = 20'd389566;
                    SRI_48K: rcp = 20'd357913;
                    SRI_32K: rcp = 20'd536870;
                    default: rcp = '0;
                endcase
            end
            default: rcp = '0;
        endcase
        return rcp;
    endfunction

endpackage

[rtl/mafhd_front.sv]
// ----------------------------------------------------------------------------
// mafhd_front
// unpacks a header word, looks up rates and classifies the length formula
// ----------------------------------------------------------------------------
module mafhd_front (
    input  logic [mafhd_pkg::HDR_W-1:0] i_header_word,
    output mafhd_pkg::t_item            o_item
);
    import mafhd_pkg::*;

    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b2;
    logic [1:0]        ver;
    logic [1:0]        lay;
    logic [1:0]        sri;
    logic              sync;
    logic [KBPS_W-1:0] kbps;
    logic [HZ_W-1:0]   hz;

    assign b0   = i_header_word[31:24];
    assign b1   = i_header_word[23:16];
    assign b2   = i_header_word[15:8];
    assign ver  = b1[4:3];
    assign lay  = b1[2:1];
    assign sri  = b2[3:2];
    assign sync = (b0 == SYNC_BYTE0) && ((b1 & SYNC_MASK1) == SYNC_MASK1);
    assign kbps = kbps_lookup(ver, lay, b2[7:4]);
    assign hz   = hz_lookup(ver, sri);

    always_comb begin
        o_item.sync_ok        = sync;
        o_item.version_code   = ver;
        o_item.layer_code     = lay;
        o_item.crc_present    = ~b1[0];
        o_item.padded         = b2[1];
        o_item.bitrate_kbps   = kbps;
        o_item.sample_rate_hz = hz;
        o_item.calc_ok        = sync && (kbps != '0) && (hz != '0);
        o_item.recip          = recip_lookup(ver, sri);
        if (lay == LAY_I) begin
            o_item.len_mode = LEN_L1;
        end else if (lay == LAY_II || ver == VER_MPEG1) begin
            o_item.len_mode = LEN_FULL;
        end else begin
            o_item.len_mode = LEN_HALF;
        end
    end

endmodule

[rtl/mafhd_fifo.sv]
// ----------------------------------------------------------------------------
// mafhd_fifo
// short queue of classified headers between front and back
// ----------------------------------------------------------------------------
module mafhd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mafhd_pkg::t_item  i_item,
    output logic              o_full,
    input  logic              i_take,
    output mafhd_pkg::t_item  o_item,
    output logic              o_empty
);
    import mafhd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_cnt == FULLC);
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_push && !o_full;
    assign do_rd   = i_take && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr  = do_wr ? ((r_wr == LAST) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = do_rd ? ((r_rd == LAST) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt;
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

[rtl/mafhd_back.sv]
// ----------------------------------------------------------------------------
// mafhd_back
// frame length pipeline: numerator, reciprocal multiply, quotient times rate, correction, output
// ----------------------------------------------------------------------------
module mafhd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mafhd_pkg::t_item            i_item,
    input  logic                        i_item_valid,
    output logic                        o_item_take,
    input  logic                        i_pop,
    output logic                        o_empty,
    output mafhd_pkg::t_item            o_item,
    output logic [mafhd_pkg::LEN_W-1:0] o_frame_bytes
);
    import mafhd_pkg::*;

    localparam int PROD1_W = COEF_W + KBPS_W;
    localparam int PROD2_W = NUM_W + RCP_W;
    localparam int PROD3_W = QUO_W + HZ_W;

    logic              en;
    logic              r_v1, r_v2, r_v3, r_v4;
    t_item             r_i1, r_i2, r_i3, r_i4;
    logic [NUM_W-1:0]  r_num1, r_num2, r_num3;
    logic [QUO_W-1:0]  r_qest2, r_qest3;
    logic [NUM_W-1:0]  r_qsr3;
    logic [LEN_W-1:0]  r_len4;

    logic [COEF_W-1:0]  coef;
    logic [PROD1_W-1:0] prod1;
    logic [PROD2_W-1:0] prod2;
    logic [PROD3_W-1:0] prod3;
    logic [NUM_W-1:0]   rem;
    logic [QUO_W-1:0]   quo;
    logic [QUO_W-1:0]   base;
    logic [QUO_W+1:0]   base_x4;
    logic [LEN_W-1:0]   n_len4;

    assign en          = !r_v4 || i_pop;
    assign o_item_take = en;
    assign o_empty     = !r_v4;
    assign o_item      = r_i4;
    assign o_frame_bytes = r_len4;

    always_comb begin
        case (i_item.len_mode)
            LEN_L1:   coef = COEF_L1;
            LEN_HALF: coef = COEF_HALF;
            default:  coef = COEF_FULL;
        endcase
    end

    assign prod1 = coef * i_item.bitrate_kbps;
    assign prod2 = r_num1 * r_i1.recip;
    assign prod3 = r_qest2 * r_i2.sample_rate_hz;

    always_comb begin
        rem     = r_num3 - r_qsr3;
        quo     = (rem >= NUM_W'(r_i3.sample_rate_hz)) ? r_qest3 + 1'b1 : r_qest3;
        base    = quo + QUO_W'(r_i3.padded);
        base_x4 = {base, 2'b00};
        if (!r_i3.calc_ok) begin
            n_len4 = '0;
        end else if (r_i3.len_mode == LEN_L1) begin
            n_len4 = base_x4[LEN_W-1:0];
        end else begin
            n_len4 = base[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_item_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i1    <= i_item;
            r_num1  <= prod1[NUM_W-1:0];
            r_i2    <= r_i1;
            r_num2  <= r_num1;
            r_qest2 <= prod2[PROD2_W-1:RCP_SHIFT];
            r_i3    <= r_i2;
            r_num3  <= r_num2;
            r_qest3 <= r_qest2;
            r_qsr3  <= prod3[NUM_W-1:0];
            r_i4    <= r_i3;
            r_len4  <= n_len4;
        end
    end

endmodule

[rtl/mpeg_audio_frame_header_decode_top.sv]
// path: accepted header -> queue -> four-stage length pipeline -> outputs
// throughput: one header per cycle unless stalled, set by the length pipeline
// a result waiting at the output stalls the pipeline; headers keep filling
// the QUEUE_DEPTH-entry queue behind it until full rises
// reset: synchronous active-low, empties queue and pipeline, no clearing pass
// ----------------------------------------------------------------------------
// mpeg_audio_frame_header_decode_top
// decodes mpeg audio frame header words into fields, rates and frame length
// ----------------------------------------------------------------------------
module mpeg_audio_frame_header_decode_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [mafhd_pkg::HDR_W-1:0]  i_header_word,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_sync_ok,
    output logic [1:0]                   o_version_code,
    output logic [1:0]                   o_layer_code,
    output logic                         o_crc_present,
    output logic                         o_padded,
    output logic [mafhd_pkg::KBPS_W-1:0] o_bitrate_kbps,
    output logic [mafhd_pkg::HZ_W-1:0]   o_sample_rate_hz,
    output logic [mafhd_pkg::LEN_W-1:0]  o_frame_bytes
);
    import mafhd_pkg::*;

    t_item front_item;
    t_item queue_item;
    t_item out_item;
    logic  queue_empty;
    logic  back_take;

    mafhd_front u_front (
        .i_header_word (i_header_word),
        .o_item        (front_item)
    );

    mafhd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_take  (back_take),
        .o_item  (queue_item),
        .o_empty (queue_empty)
    );

    mafhd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (queue_item),
        .i_item_valid  (!queue_empty),
        .o_item_take   (back_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_item        (out_item),
        .o_frame_bytes (o_frame_bytes)
    );

    assign o_sync_ok        = out_item.sync_ok;
    assign o_version_code   = out_item.version_code;
    assign o_layer_code     = out_item.layer_code;
    assign o_crc_present    = out_item.crc_present;
    assign o_padded         = out_item.padded;
    assign o_bitrate_kbps   = out_item.bitrate_kbps;
    assign o_sample_rate_hz = out_item.sample_rate_hz;

endmodule

[sim/tb_mpeg_audio_frame_header_decode_top.sv]
// ----------------------------------------------------------------------------
// tb_mpeg_audio_frame_header_decode_top
// Self-checking testbench for the MPEG audio frame header decoder. A driver
// pushes header words from a pending queue with random gaps. A monitor pops
// results with random stalls and one long hold-off, so the block fills up
// and raises full. Every result is compared field by field with a local
// decode of the same header: sync, version, layer, CRC flag, padding,
// table bitrate and sample rate, and frame length. The stimulus starts with
// directed corner headers and goes on with mostly well-formed random headers
// mixed with noise and broken ones.
// ----------------------------------------------------------------------------
module tb_mpeg_audio_frame_header_decode_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mafhd_pkg::*;

    localparam int N_RANDOM    = 900;
    localparam int CYCLE_LIMIT = 50000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 250;
    localparam int QUIET_FROM  = 500;
    localparam int QUIET_TO    = 650;

    // rows: mpeg1 l1, mpeg1 l2, mpeg1 l3, mpeg2/2.5 l1, mpeg2/2.5 l2 and l3
    localparam int unsigned KBPS_TAB [5][16] = '{
        '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
        '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
        '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
    };
    localparam int unsigned HZ_TAB [4][4] = '{
        '{11025, 12000, 8000, 0},
        '{0, 0, 0, 0},
        '{22050, 24000, 16000, 0},
        '{44100, 48000, 32000, 0}
    };

    typedef struct packed {
        logic              sync_ok;
        logic [1:0]        version_code;
        logic [1:0]        layer_code;
        logic              crc_present;
        logic              padded;
        logic [KBPS_W-1:0] bitrate_kbps;
        logic [HZ_W-1:0]   sample_rate_hz;
        logic [LEN_W-1:0]  frame_bytes;
    } t_decoded;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push    = 1'b0;
    logic              pop     = 1'b0;
    logic [HDR_W-1:0]  i_header_word = '0;
    logic              full;
    logic              empty;
    logic              o_sync_ok;
    logic [1:0]        o_version_code;
    logic [1:0]        o_layer_code;
    logic              o_crc_present;
    logic              o_padded;
    logic [KBPS_W-1:0] o_bitrate_kbps;
    logic [HZ_W-1:0]   o_sample_rate_hz;
    logic [LEN_W-1:0]  o_frame_bytes;

    logic [HDR_W-1:0] pending_hdrs [$];
    t_decoded         expected_decodes [$];

    int n_acc         = 0;
    int n_checked     = 0;
    int n_framed      = 0;
    int n_full_stalls = 0;
    int n_err         = 0;
    int n_cycles      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    mpeg_audio_frame_header_decode_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_header_word    (i_header_word),
        .empty            (empty),
        .pop              (pop),
        .o_sync_ok        (o_sync_ok),
        .o_version_code   (o_version_code),
        .o_layer_code     (o_layer_code),
        .o_crc_present    (o_crc_present),
        .o_padded         (o_padded),
        .o_bitrate_kbps   (o_bitrate_kbps),
        .o_sample_rate_hz (o_sample_rate_hz),
        .o_frame_bytes    (o_frame_bytes)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_decoded decode_header(input logic [HDR_W-1:0] w);
        t_decoded    d;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [2:0]  row;
        int unsigned br;
        int unsigned sr;
        int unsigned len;
        b0 = w[31:24];
        b1 = w[23:16];
        b2 = w[15:8];
        d.sync_ok      = (b0 == 8'hFF) && ((b1 & 8'hE0) == 8'hE0);
        d.version_code = b1[4:3];
        d.layer_code   = b1[2:1];
        d.crc_present  = ~b1[0];
        d.padded       = b2[1];
        br = 0;
        if (d.version_code != VER_RSVD && d.layer_code != LAY_RSVD) begin
            if (d.version_code == VER_MPEG1) begin
                row = 3'(3 - d.layer_code);
            end else begin
                row = (d.layer_code == LAY_I) ? 3'd3 : 3'd4;
            end
            br = KBPS_TAB[row][b2[7:4]];
        end
        sr  = HZ_TAB[d.version_code][b2[3:2]];
        len = 0;
        if (d.sync_ok && br != 0 && sr != 0) begin
            if (d.layer_code == LAY_I) begin
                len = (12000 * br / sr + d.padded) * 4;
            end else if (d.layer_code == LAY_II || d.version_code == VER_MPEG1) begin
                len = 144000 * br / sr + d.padded;
            end else begin
                len = 72000 * br / sr + d.padded;
            end
        end
        d.bitrate_kbps   = br[KBPS_W-1:0];
        d.sample_rate_hz = sr[HZ_W-1:0];
        d.frame_bytes    = len[LEN_W-1:0];
        return d;
    endfunction

    // sync bits set, protection, private bit and last byte random
    function automatic logic [HDR_W-1:0] make_header(
        input logic [1:0] ver,
        input logic [1:0] lay,
        input logic [3:0] bri,
        input logic [1:0] sri,
        input logic       pad
    );
        logic [HDR_W-1:0] w;
        w = $urandom;
        w[31:21] = '1;
        w[20:19] = ver;
        w[18:17] = lay;
        w[15:12] = bri;
        w[11:10] = sri;
        w[9]     = pad;
        return w;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            n_err++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                expected_decodes.push_back(decode_header(i_header_word));
                void'(pending_hdrs.pop_front());
                n_acc++;
            end
            if (push && full) begin
                n_full_stalls++;
            end else begin
                offer = (pending_hdrs.size() != 0) &&
                        ((n_acc >= QUIET_FROM && n_acc < QUIET_TO) ||
                         $urandom_range(0, 99) >= 14);
                push <= offer;
                if (offer) begin
                    i_header_word <= pending_hdrs[0];
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_decoded d;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_decodes.size() == 0) begin
                    $error("result with no request pending");
                    n_err++;
                end else begin
                    d = expected_decodes.pop_front();
                    check_field("sync_ok", 32'(d.sync_ok), 32'(o_sync_ok));
                    check_field("version_code", 32'(d.version_code),
                                32'(o_version_code));
                    check_field("layer_code", 32'(d.layer_code), 32'(o_layer_code));
                    check_field("crc_present", 32'(d.crc_present), 32'(o_crc_present));
                    check_field("padded", 32'(d.padded), 32'(o_padded));
                    check_field("bitrate_kbps", 32'(d.bitrate_kbps),
                                32'(o_bitrate_kbps));
                    check_field("sample_rate_hz", 32'(d.sample_rate_hz),
                                32'(o_sample_rate_hz));
                    check_field("frame_bytes", 32'(d.frame_bytes), 32'(o_frame_bytes));
                    if (d.frame_bytes != 0) begin
                        n_framed++;
                    end
                end
                n_checked++;
            end
            if (!hold_done && n_checked >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= (n_checked >= QUIET_FROM && n_checked < QUIET_TO) ||
                       ($urandom_range(0, 99) >= 14);
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int          kind;
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [HDR_W-1:0] w;

        // directed corners
        pending_hdrs.push_back('0);
        pending_hdrs.push_back('1);
        w = make_header(VER_MPEG1, LAY_III, 4'd9, SRI_44K, 1'b0);
        w[24] = 1'b0;
        pending_hdrs.push_back(w);
        w = make_header(VER_MPEG1, LAY_II, 4'd9, SRI_48K, 1'b1);
        w[21] = 1'b0;
        pending_hdrs.push_back(w);
        pending_hdrs.push_back(make_header(VER_RSVD, LAY_III, 4'd9, SRI_44K, 1'b0));
        pending_hdrs.push_back(make_header(VER_MPEG1, LAY_RSVD, 4'd9, SRI_44K, 1'b0));
        pending_hdrs.push_back(make_header(VER_MPEG1, LAY_III, 4'd0, SRI_44K, 1'b1));
        pending_hdrs.push_back(make_header(VER_MPEG2, LAY_II, 4'd15, SRI_48K, 1'b0));
        pending_hdrs.push_back(make_header(VER_MPEG1, LAY_I, 4'd5, SRI_RSVD, 1'b0));
        pending_hdrs.push_back(make_header(VER_MPEG1, LAY_I, 4'd14, SRI_32K, 1'b1));
        pending_hdrs.push_back(make_header(VER_MPEG25, LAY_II, 4'd14, SRI_32K, 1'b1));
        pending_hdrs.push_back(make_header(VER_MPEG1, LAY_I, 4'd1, SRI_44K, 1'b0));
        pending_hdrs.push_back(make_header(VER_MPEG1, LAY_II, 4'd14, SRI_32K, 1'b1));
        pending_hdrs.push_back(make_header(VER_MPEG1, LAY_III, 4'd1, SRI_48K, 1'b0));
        pending_hdrs.push_back(make_header(VER_MPEG2, LAY_I, 4'd14, SRI_44K, 1'b1));
        pending_hdrs.push_back(make_header(VER_MPEG2, LAY_II, 4'd1, SRI_48K, 1'b0));
        pending_hdrs.push_back(make_header(VER_MPEG2, LAY_III, 4'd14, SRI_32K, 1'b1));
        pending_hdrs.push_back(make_header(VER_MPEG25, LAY_I, 4'd1, SRI_32K, 1'b0));
        pending_hdrs.push_back(make_header(VER_MPEG25, LAY_III, 4'd14, SRI_44K, 1'b1));
        pending_hdrs.push_back(make_header(VER_MPEG25, LAY_I, 4'd14, SRI_48K, 1'b1));

        // random: mostly well-formed, the rest loosely formed, broken sync or noise
        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                case ($urandom_range(0, 2))
                    0:       ver = VER_MPEG25;
                    1:       ver = VER_MPEG2;
                    default: ver = VER_MPEG1;
                endcase
                lay = 2'($urandom_range(1, 3));
                w = make_header(ver, lay, 4'($urandom_range(1, 14)),
                                2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
            end else if (kind < 85) begin
                w = make_header(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                                1'($urandom_range(0, 1)));
            end else if (kind < 93) begin
                w = make_header(VER_MPEG1, 2'($urandom_range(1, 3)),
                                4'($urandom_range(1, 14)), 2'($urandom_range(0, 2)),
                                1'($urandom_range(0, 1)));
                w[5'($urandom_range(21, 31))] = 1'b0;
            end else begin
                w = $urandom;
            end
            pending_hdrs.push_back(w);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_hdrs.size() != 0 || push || expected_decodes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("decoded %0d headers, %0d with a frame length, input stalled %0d cycles",
                 n_checked, n_framed, n_full_stalls);
        if (n_err == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mafhd_pkg.sv
rtl/mafhd_front.sv
rtl/mafhd_fifo.sv
rtl/mafhd_back.sv
rtl/mpeg_audio_frame_header_decode_top.sv
sim/tb_mpeg_audio_frame_header_decode_top.sv
